>>> src/nat_pkg.sv
// ----------------------------------------------------------------------------
// nat_pkg
// shared widths, operation codes, status codes and register map of the
// neighbour address table
// ----------------------------------------------------------------------------
package nat_pkg;

	localparam int MODE_W     = 2;
	localparam int IFN_W      = 8;
	localparam int HALF_W     = 64;
	localparam int MAC_W      = 48;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 7;
	localparam int CAP_W      = 7;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CAP_W-1:0]    cap_t;

	// operations
	localparam mode_t MODE_LOOKUP = 2'd0;
	localparam mode_t MODE_LEARN  = 2'd1;
	localparam mode_t MODE_REMOVE = 2'd2;

	// result status
	localparam status_t ST_MISS     = 3'd0;
	localparam status_t ST_HIT      = 3'd1;
	localparam status_t ST_APPENDED = 3'd2;
	localparam status_t ST_EVICTED  = 3'd3;
	localparam status_t ST_IGNORED  = 3'd4;

	// register map (word index)
	localparam logic REG_TABLE_CAPACITY = 1'b0;
	localparam cap_t CAP_RESET          = 7'd64;

endpackage

>>> src/nat_if.sv
// ----------------------------------------------------------------------------
// nat channels
// request and result channels of the neighbour address table
// ----------------------------------------------------------------------------
interface nat_req_if;
	logic                          valid;
	logic                          ready;
	nat_pkg::mode_t                mode;
	logic [nat_pkg::IFN_W-1:0]     interface_number;
	logic [nat_pkg::HALF_W-1:0]    address_high;
	logic [nat_pkg::HALF_W-1:0]    address_low;
	logic [nat_pkg::MAC_W-1:0]     link_address;

	modport source (output valid, mode, interface_number, address_high, address_low,
		link_address, input ready);
	modport sink (input valid, mode, interface_number, address_high, address_low,
		link_address, output ready);
endinterface

interface nat_rsp_if;
	logic                          valid;
	logic                          ready;
	nat_pkg::status_t              status;
	logic [nat_pkg::MAC_W-1:0]     found_link_address;
	logic [nat_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, status, found_link_address, entry_count, input ready);
	modport sink (input valid, status, found_link_address, entry_count, output ready);
endinterface

>>> src/neighbor_address_table.sv
// ----------------------------------------------------------------------------
// neighbor_address_table
// ipv6 neighbour cache: interface and address to link address, searched
// in slot order from a single entry memory
// ----------------------------------------------------------------------------
// Each request (lookup, learn or remove) is taken when the block is idle and
// answered with exactly one result. The entries live in one synchronous
// memory with a registered read; a request walks the valid entries from slot 0
// upward, one memory read per cycle, and stops at the first match. A remove
// that hits copies the last entry into the hole, and an evicting learn moves
// the last entry to slot 0 and then writes the new one into the last slot; a
// request on an empty table skips the search, and an invalid mode or a learn
// at capacity zero is answered without touching the memory. The result sits
// in an output register, so the next request is accepted while the previous
// result still waits. Entries above the count are never read, so the memory
// needs no clearing after reset.
// table_capacity (APB byte address 0, reset 64) limits learning; lowering it
// below the count keeps the existing entries and makes every new learn evict,
// while a capacity of zero has every learn answered as ignored.
// ----------------------------------------------------------------------------
module neighbor_address_table #(
	parameter int MAX_ENTRIES    = 64,
	parameter int INTERFACE_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nat_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nat_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nat_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	nat_req_if.sink                           req,
	nat_rsp_if.source                         rsp
);

	// slot index, count and compare widths
	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > nat_pkg::CAP_W) ? CW : nat_pkg::CAP_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_MV_WR  = 3'd3;
	localparam logic [2:0] S_NEW_WR = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	typedef struct packed {
		logic [INTERFACE_BITS-1:0]   ifn;
		logic [nat_pkg::HALF_W-1:0]  hi;
		logic [nat_pkg::HALF_W-1:0]  lo;
		logic [nat_pkg::MAC_W-1:0]   mac;
	} entry_t;

	// configuration
	nat_pkg::cap_t capacity;

	nat_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// control state
	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           rd_idx_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic                    hit_q;
	logic [AW-1:0]           slot_q;
	nat_pkg::status_t        st_q;
	logic                    out_vld_q;

	// request payload
	nat_pkg::mode_t          mode_q;
	entry_t                  key_q;
	logic [nat_pkg::MAC_W-1:0] found_q;

	// result payload
	nat_pkg::status_t        out_status_q;
	logic [nat_pkg::MAC_W-1:0] out_mac_q;
	logic [nat_pkg::COUNT_W-1:0] out_count_q;

	// entry memory
	entry_t                  mem [MAX_ENTRIES];
	entry_t                  rd_data_s1;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	entry_t                  wr_data;

	// derived
	logic [CMPW-1:0]         cap_x;
	logic [CMPW-1:0]         cap_eff;
	logic                    full;
	logic [AW-1:0]           last_idx;
	logic                    match;
	logic                    is_learn;
	logic                    is_remove;
	logic                    need_move;
	logic                    accept;

	// effective capacity is the smaller of the register and the memory depth
	assign cap_x   = CMPW'(capacity);
	assign cap_eff = (cap_x < CMPW'(MAX_ENTRIES)) ? cap_x : CMPW'(MAX_ENTRIES);
	assign full    = (CMPW'(count_q) >= cap_eff);

	assign last_idx  = AW'(count_q - CW'(1));
	assign is_learn  = (mode_q == nat_pkg::MODE_LEARN);
	assign is_remove = (mode_q == nat_pkg::MODE_REMOVE);
	// an evicting learn and a hitting remove both copy the last entry
	assign need_move = (is_learn && !hit_q && full) || (is_remove && hit_q);

	// compare of the entry read in the previous cycle
	assign match = rd_vld_s1 && (rd_data_s1.ifn == key_q.ifn) &&
		(rd_data_s1.hi == key_q.hi) && (rd_data_s1.lo == key_q.lo);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid              = out_vld_q;
	assign rsp.status             = out_status_q;
	assign rsp.found_link_address = out_mac_q;
	assign rsp.entry_count        = out_count_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = key_q;
		unique case (state_q)
			S_SEARCH: begin
				rd_en = (rd_idx_q < count_q);
			end
			S_DECIDE: begin
				rd_addr = last_idx;
				priority if (need_move) begin
					rd_en = 1'b1;
				end else if (is_learn && hit_q) begin
					// update in place, key unchanged
					wr_en = 1'b1;
				end else if (is_learn) begin
					// append behind the last valid slot
					wr_en   = 1'b1;
					wr_addr = AW'(count_q);
				end else begin
				end
			end
			S_MV_WR: begin
				// last entry goes to slot 0 on eviction, into the hole on remove
				wr_en   = 1'b1;
				wr_addr = is_learn ? '0 : slot_q;
				wr_data = rd_data_s1;
			end
			S_NEW_WR: begin
				wr_en   = 1'b1;
				wr_addr = last_idx;
			end
			default: begin
			end
		endcase
	end

	// single-port write, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// search pipeline tag: which slot the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SEARCH) && rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			hit_q    <= 1'b0;
			st_q     <= nat_pkg::ST_MISS;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						st_q     <= nat_pkg::ST_MISS;
						priority if (req.mode != nat_pkg::MODE_LOOKUP &&
							req.mode != nat_pkg::MODE_LEARN &&
							req.mode != nat_pkg::MODE_REMOVE) begin
							// unused code: plain miss, nothing changes
							state_q <= S_RESP;
						end else if (req.mode == nat_pkg::MODE_LEARN && cap_eff == '0) begin
							st_q    <= nat_pkg::ST_IGNORED;
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_DECIDE;
					end else if (rd_vld_s1 && rd_idx_s1 == last_idx) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					priority if (is_learn && hit_q) begin
						st_q    <= nat_pkg::ST_HIT;
						state_q <= S_RESP;
					end else if (is_learn && full) begin
						st_q    <= nat_pkg::ST_EVICTED;
						state_q <= S_MV_WR;
					end else if (is_learn) begin
						count_q <= count_q + CW'(1);
						st_q    <= nat_pkg::ST_APPENDED;
						state_q <= S_RESP;
					end else if (is_remove && hit_q) begin
						count_q <= count_q - CW'(1);
						st_q    <= nat_pkg::ST_HIT;
						state_q <= S_MV_WR;
					end else begin
						st_q    <= hit_q ? nat_pkg::ST_HIT : nat_pkg::ST_MISS;
						state_q <= S_RESP;
					end
				end
				S_MV_WR: begin
					state_q <= is_learn ? S_NEW_WR : S_RESP;
				end
				S_NEW_WR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and match capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= req.mode;
			key_q.ifn  <= INTERFACE_BITS'(req.interface_number);
			key_q.hi   <= req.address_high;
			key_q.lo   <= req.address_low;
			key_q.mac  <= req.link_address;
			found_q    <= '0;
		end else if (state_q == S_SEARCH && match) begin
			slot_q <= rd_idx_s1;
			if (mode_q == nat_pkg::MODE_LOOKUP) begin
				found_q <= rd_data_s1.mac;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_vld_q || rsp.ready)) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_vld_q || rsp.ready)) begin
			out_status_q <= st_q;
			out_mac_q    <= found_q;
			out_count_q  <= nat_pkg::COUNT_W'(count_q);
		end
	end

`ifndef SYNTHESIS
	// count never outgrows the memory
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond memory depth");

	// no memory write while searching or idle
	a_no_write_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_SEARCH) |-> !wr_en)
		else $error("memory write outside the update states");

	// a hit always points at a valid slot
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && hit_q) |-> (CW'(slot_q) < count_q))
		else $error("hit slot at or above the count");

	// the count moves only on the decision cycle
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DECIDE) |=> $stable(count_q))
		else $error("entry count changed outside the decision cycle");

	// ignored status only for a learn
	a_ignored_learn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && st_q == nat_pkg::ST_IGNORED) |-> is_learn)
		else $error("ignored status on a request that is not a learn");
`endif

endmodule

>>> src/nat_cfg_regs.sv
// ----------------------------------------------------------------------------
// nat_cfg_regs
// apb register block holding the table capacity
// ----------------------------------------------------------------------------
module nat_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nat_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nat_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nat_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output nat_pkg::cap_t                     capacity
);

	nat_pkg::cap_t capacity_q;
	logic          sel_cap;

	assign sel_cap  = (paddr[nat_pkg::APB_ADDR_W-1] == nat_pkg::REG_TABLE_CAPACITY);
	assign pready   = 1'b1;
	assign capacity = capacity_q;
	assign prdata   = sel_cap ? nat_pkg::APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= nat_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			capacity_q <= pwdata[nat_pkg::CAP_W-1:0];
		end
	end

endmodule
